@@ rtl/core/box_blur_3x3_edge_aware_defines.svh @@
// ----------------------------------------------------------------------------
// box blur assertion macros
// concurrent assertion helpers on clk_i with rst_ni low as disable
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BB3_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BB3_ASSERT_IMPL(label, ante, cons, msg)
`define BB3_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg
// shared constants and types of the 3x3 edge-aware box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned PIX_W     = 24;
  localparam int unsigned DEPTH     = 3 * MAX_WIDTH;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned DIVD_W    = 13;
  localparam int unsigned DIVS_W    = 5;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                         start;
    logic [DIVS_W-1:0]            divisor;
    logic [2:0][DIVD_W-1:0]       dividend;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            busy;
    logic [2:0][7:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_ACC   = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

endpackage

@@ rtl/core/bb3_ram.sv @@
// ----------------------------------------------------------------------------
// bb3_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 3072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bb3_div.sv @@
// ----------------------------------------------------------------------------
// bb3_div
// restoring divider, one quotient bit per cycle, three channel lanes
// ----------------------------------------------------------------------------
module bb3_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bb3_pkg::div_req_t req_i,
  output bb3_pkg::div_rsp_t rsp_o
);

  logic [2:0][bb3_pkg::DIVD_W-1:0] rem_q;
  logic [2:0][7:0]                 quot_q;
  logic [bb3_pkg::DIVD_W-1:0]      dsh_q;
  logic [2:0]                      step_q;
  logic                            busy_q;
  logic                            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      dsh_q <= bb3_pkg::DIVD_W'(req_i.divisor) << 7;
    end else if (busy_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= dsh_q) begin
          rem_q[ch]  <= rem_q[ch] - dsh_q;
          quot_q[ch] <= {quot_q[ch][6:0], 1'b1};
        end else begin
          quot_q[ch] <= {quot_q[ch][6:0], 1'b0};
        end
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ rtl/core/box_blur_3x3_edge_aware.sv @@
// sequence: each accepted pixel is first written to the row store; then each pending
// result sums its neighbors, is divided and is held on the output until taken
// input: a new pixel is taken only once all 0..4 results of the last one are out
// reset: counters, rotation and handshakes clear; width 1024, height 1
// the row store holds no reset and is not cleared
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// raster-order rgb 3x3 box blur with edge-aware neighbor count
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_aware_defines.svh"

module box_blur_3x3_edge_aware (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [15:0] out_row_o,
  output logic [9:0]  out_col_o,
  output logic        last_of_run_o,
  output logic        frame_done_o
);

  localparam int unsigned CW = bb3_pkg::COL_W;
  localparam int unsigned RW = bb3_pkg::ROW_W;
  localparam int unsigned AW = bb3_pkg::ADDR_W;
  localparam int unsigned SW = bb3_pkg::SUM_W;

  bb3_pkg::state_e state_q, state_d;

  logic [10:0]   width_q;
  logic [15:0]   height_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [1:0]    rot_q;

  logic [RW-1:0] i_q, hm1_q, cur_r_q;
  logic [CW-1:0] j_q, wm1_q, cur_c_q;
  logic [1:0]    crot_q;
  logic [23:0]   pix_q;
  logic [3:0]    pend_q;
  logic          cur_ri_q;
  logic [3:0]    nb_q;
  logic [1:0]    dr_q, dc_q;
  logic          vd_q;
  logic [2:0][SW-1:0] sum_q, sum_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          out_valid_q;
  logic [2:0][7:0] out_pix_q;
  logic [RW-1:0] out_row_q;
  logic [CW-1:0] out_col_q;
  logic          out_last_q, out_frame_q;

  // frame geometry
  logic [10:0]   w_eff;
  logic [CW-1:0] wm1, j_c;
  logic [RW-1:0] hm1, i_c;
  logic          row_end, last_row;
  logic [3:0]    mask;
  logic          accept;

  always_comb begin
    if (width_q == 11'd0) begin
      w_eff = 11'd1;
    end else if (width_q > 11'(bb3_pkg::MAX_WIDTH)) begin
      w_eff = 11'(bb3_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    wm1 = CW'(w_eff - 11'd1);
    hm1 = (height_q == 16'd0) ? '0 : height_q - 16'd1;
    j_c = ({1'b0, col_q} >= w_eff) ? wm1 : col_q;
    i_c = (row_q > hm1) ? hm1 : row_q;
    row_end  = (j_c == wm1);
    last_row = (i_c == hm1);
    mask[0] = (i_c != '0) && (j_c != '0);
    mask[1] = (i_c != '0) && row_end;
    mask[2] = last_row && (j_c != '0);
    mask[3] = last_row && row_end;
  end

  assign in_ready_o = (state_q == bb3_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next result pick
  logic [1:0] pick;
  logic [3:0] pend_rest;
  always_comb begin
    if (pend_q[0]) begin
      pick = 2'd0;
    end else if (pend_q[1]) begin
      pick = 2'd1;
    end else if (pend_q[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
    pend_rest = pend_q & ~(4'b0001 << pick);
  end

  // neighbor address
  logic       r_ok, c_ok, nb_ok;
  logic [1:0] back;
  logic [2:0] st_tmp;
  logic [1:0] store;
  logic [CW-1:0] ncol;
  logic [AW-1:0] rd_addr, wr_addr, ram_addr;
  logic [23:0]   rdata;
  logic          ram_we;

  always_comb begin
    r_ok = !((dr_q == 2'd0) && (cur_r_q == '0)) && !((dr_q == 2'd2) && cur_ri_q);
    c_ok = !((dc_q == 2'd0) && (cur_c_q == '0)) && !((dc_q == 2'd2) && (cur_c_q == wm1_q));
    nb_ok = r_ok && c_ok && (nb_q < 4'd9);
    back  = {1'b0, !cur_ri_q} + 2'd1 - dr_q;
    st_tmp = {1'b0, crot_q} + 3'd3 - {1'b0, back};
    store  = (st_tmp >= 3'd3) ? 2'(st_tmp - 3'd3) : st_tmp[1:0];
    ncol   = cur_c_q + CW'(dc_q) - CW'(1);
    rd_addr = AW'(store) * AW'(bb3_pkg::MAX_WIDTH) + AW'(ncol);
    wr_addr = AW'(crot_q) * AW'(bb3_pkg::MAX_WIDTH) + AW'(j_q);
    ram_we   = (state_q == bb3_pkg::S_WRITE);
    ram_addr = ram_we ? wr_addr : rd_addr;
  end

  bb3_ram #(
    .WIDTH (bb3_pkg::PIX_W),
    .DEPTH (bb3_pkg::DEPTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pix_q),
    .rdata_o (rdata)
  );

  // accumulate
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = sum_q[ch] + (vd_q ? SW'(rdata[8*ch +: 8]) : '0);
    end
    cnt_d = cnt_q + (vd_q ? 4'd1 : 4'd0);
  end

  bb3_pkg::div_req_t div_req;
  bb3_pkg::div_rsp_t div_rsp;

  always_comb begin
    div_req.start   = (state_q == bb3_pkg::S_ACC) && (nb_q == 4'd9);
    div_req.divisor = {cnt_d, 1'b0};
    for (int ch = 0; ch < 3; ch++) begin
      div_req.dividend[ch] = {sum_d[ch], 1'b0} + bb3_pkg::DIVD_W'(cnt_d);
    end
  end

  bb3_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      bb3_pkg::S_IDLE:  if (accept) state_d = bb3_pkg::S_WRITE;
      bb3_pkg::S_WRITE: state_d = (pend_q != '0) ? bb3_pkg::S_ACC : bb3_pkg::S_IDLE;
      bb3_pkg::S_ACC:   if (nb_q == 4'd9) state_d = bb3_pkg::S_DIV;
      bb3_pkg::S_DIV:   if (div_rsp.done) state_d = bb3_pkg::S_OUT;
      bb3_pkg::S_OUT: begin
        if (out_ready_i) begin
          state_d = (pend_q != '0) ? bb3_pkg::S_ACC : bb3_pkg::S_IDLE;
        end
      end
      default: state_d = bb3_pkg::S_IDLE;
    endcase
  end

  logic start_res;
  assign start_res = ((state_q == bb3_pkg::S_WRITE) ||
                      ((state_q == bb3_pkg::S_OUT) && out_ready_i)) && (pend_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bb3_pkg::S_IDLE;
      width_q     <= 11'(bb3_pkg::MAX_WIDTH);
      height_q    <= 16'd1;
      row_q       <= '0;
      col_q       <= '0;
      rot_q       <= '0;
      pend_q      <= '0;
      nb_q        <= '0;
      vd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bb3_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i[10:0];
          bb3_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        pend_q <= mask;
        if (row_end) begin
          col_q <= '0;
          rot_q <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
          row_q <= last_row ? '0 : i_c + RW'(1);
        end else begin
          col_q <= j_c + CW'(1);
          row_q <= i_c;
        end
      end
      if (start_res) begin
        pend_q <= pend_rest;
        nb_q   <= '0;
        vd_q   <= 1'b0;
      end else if (state_q == bb3_pkg::S_ACC) begin
        vd_q <= nb_ok;
        if (nb_q != 4'd9) begin
          nb_q <= nb_q + 4'd1;
        end
      end
      if (div_rsp.done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      i_q    <= i_c;
      j_q    <= j_c;
      wm1_q  <= wm1;
      hm1_q  <= hm1;
      crot_q <= (rot_q == 2'd3) ? 2'd0 : rot_q;
      pix_q  <= {blue_in_i, green_in_i, red_in_i};
    end
    if (start_res) begin
      cur_ri_q <= pick[1];
      cur_r_q  <= pick[1] ? i_q : i_q - RW'(1);
      cur_c_q  <= pick[0] ? j_q : j_q - CW'(1);
      dr_q     <= '0;
      dc_q     <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else if (state_q == bb3_pkg::S_ACC) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (dc_q == 2'd2) begin
        dc_q <= '0;
        dr_q <= dr_q + 2'd1;
      end else begin
        dc_q <= dc_q + 2'd1;
      end
    end
    if (div_rsp.done) begin
      out_pix_q   <= div_rsp.quot;
      out_row_q   <= cur_r_q;
      out_col_q   <= cur_c_q;
      out_last_q  <= (pend_q == '0);
      out_frame_q <= (cur_r_q == hm1_q) && (cur_c_q == wm1_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_out_o     = out_pix_q[0];
  assign green_out_o   = out_pix_q[1];
  assign blue_out_o    = out_pix_q[2];
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign last_of_run_o = out_last_q;
  assign frame_done_o  = out_frame_q;

  `BB3_ASSERT_IMPL(a_idle_no_out, in_ready_o, !out_valid_o, "output pending while idle")
  `BB3_ASSERT_IMPL(a_frame_last, out_valid_o && frame_done_o, last_of_run_o,
                   "frame end not last of run")
  `BB3_ASSERT_IMPL(a_div_done_state, div_rsp.done, state_q == bb3_pkg::S_DIV,
                   "divider done outside divide phase")
  `BB3_ASSERT_NEXT(a_start_busy, div_req.start, div_rsp.busy, "divider did not start")

endmodule
